/* rtl/utf8_stream_decoder_macros.svh */
// ----------------------------------------------------------------------------
// utf8_stream_decoder assertion macros
// Shared concurrent assertion forms, clocked on clk and held off during rst.
// ----------------------------------------------------------------------------
`ifndef UTF8_STREAM_DECODER_MACROS_SVH
`define UTF8_STREAM_DECODER_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define U8D_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Implication: when cond holds, prop holds in the same cycle.
`define U8D_ASSERT_IMPL(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) else $error(msg);

`endif

/* rtl/u8d_pkg.sv */
// ----------------------------------------------------------------------------
// u8d_pkg
// Types, constants and decode functions shared by the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
package u8d_pkg;

  localparam int HOLD_DEPTH = 5;
  localparam int RUN_DEPTH  = HOLD_DEPTH + 1;
  localparam int RUN_BITS   = RUN_DEPTH * 8;

  typedef logic [2:0] len_t;

  // Bytes waiting to be scanned, first byte in the lowest bits.
  typedef struct packed {
    logic [RUN_BITS-1:0] bytes;
    len_t                count;
  } run_t;

  typedef struct packed {
    logic [31:0] code_point;
    len_t        seq_length;
    logic        latin1_fallback;
    logic        last_of_run;
  } result_t;

  // Sequence length announced by a lead byte.
  function automatic len_t lead_len(input logic [7:0] b);
    len_t n;
    priority if (b < 8'hC0) n = 3'd1;
    else if (b < 8'hE0)     n = 3'd2;
    else if (b < 8'hF0)     n = 3'd3;
    else if (b < 8'hF8)     n = 3'd4;
    else if (b < 8'hFC)     n = 3'd5;
    else                    n = 3'd6;
    return n;
  endfunction

  // Lead payload bits followed by six bits of each continuation byte.
  function automatic logic [31:0] decode_seq(input logic [RUN_BITS-1:0] b, input len_t n);
    logic [31:0] v;
    unique case (n)
      3'd2:    v = 32'({b[4:0], b[13:8]});
      3'd3:    v = 32'({b[3:0], b[13:8], b[21:16]});
      3'd4:    v = 32'({b[2:0], b[13:8], b[21:16], b[29:24]});
      3'd5:    v = 32'({b[1:0], b[13:8], b[21:16], b[29:24], b[37:32]});
      3'd6:    v = {b[1:0], b[13:8], b[21:16], b[29:24], b[37:32], b[45:40]};
      default: v = 32'(b[7:0]);
    endcase
    return v;
  endfunction

endpackage

/* rtl/u8d_assembler.sv */
// ----------------------------------------------------------------------------
// u8d_assembler
// Collects the bytes of an open sequence and hands a finished run to the
// scanner when the sequence completes, a lone byte arrives or the string ends.
// ----------------------------------------------------------------------------
`include "utf8_stream_decoder_macros.svh"

module u8d_assembler (
  input  logic           clk,
  input  logic           rst,
  input  logic           accept,
  input  logic [7:0]     data_byte,
  input  logic           end_of_string,
  output logic           run_load,
  output u8d_pkg::run_t  run_in
);

  logic [7:0]    pending [u8d_pkg::HOLD_DEPTH];
  u8d_pkg::len_t pending_count;
  u8d_pkg::len_t needed_length;
  u8d_pkg::len_t lead_n;
  u8d_pkg::len_t run_len;
  logic          complete;

  always_comb begin
    lead_n  = u8d_pkg::lead_len(data_byte);
    run_len = pending_count + 3'd1;
    if (end_of_string) begin
      complete = 1'b1;
    end else if (pending_count == 3'd0) begin
      complete = (lead_n == 3'd1);
    end else begin
      complete = (run_len == needed_length);
    end
    run_load = accept && complete;
  end

  always_comb begin
    run_in.bytes = '0;
    for (int i = 0; i < u8d_pkg::HOLD_DEPTH; i++) begin
      if (3'(i) < pending_count) run_in.bytes[i*8 +: 8] = pending[i];
    end
    run_in.bytes[{pending_count, 3'b000} +: 8] = data_byte;
    run_in.count = run_len;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_count <= 3'd0;
      needed_length <= 3'd0;
    end else if (accept) begin
      if (complete) begin
        pending_count <= 3'd0;
        needed_length <= 3'd0;
      end else begin
        pending_count <= run_len;
        if (pending_count == 3'd0) needed_length <= lead_n;
      end
    end
  end

  // Hold the byte of an open sequence.
  always_ff @(posedge clk) begin
    if (accept && !complete) pending[pending_count] <= data_byte;
  end

  `U8D_ASSERT_IMPL(a_pending_below_need, pending_count != 3'd0,
                   pending_count < needed_length, "open sequence already complete")
  `U8D_ASSERT(a_pending_depth, pending_count <= 3'(u8d_pkg::HOLD_DEPTH),
              "pending count beyond hold depth")

endmodule

/* rtl/u8d_scanner.sv */
// ----------------------------------------------------------------------------
// u8d_scanner
// Holds one run of bytes and emits one character per cycle from its head while
// out_ready is high, decoding sequences that fit, the rest one byte at a time.
// ----------------------------------------------------------------------------
`include "utf8_stream_decoder_macros.svh"

module u8d_scanner (
  input  logic              clk,
  input  logic              rst,
  input  logic              run_load,
  input  u8d_pkg::run_t     run_in,
  input  logic              out_ready,
  output logic              can_load,
  output logic              res_valid,
  output u8d_pkg::result_t  res
);

  logic          run_valid;
  u8d_pkg::run_t run;
  logic [7:0]    head;
  u8d_pkg::len_t lead_n;
  u8d_pkg::len_t take;
  u8d_pkg::len_t remain;
  logic          advance;

  always_comb begin
    head   = run.bytes[7:0];
    lead_n = u8d_pkg::lead_len(head);
    if (lead_n == 3'd1 || lead_n > run.count) begin
      take                = 3'd1;
      res.code_point      = 32'(head);
      res.latin1_fallback = head[7];
    end else begin
      take                = lead_n;
      res.code_point      = u8d_pkg::decode_seq(run.bytes, lead_n);
      res.latin1_fallback = 1'b0;
    end
    remain          = run.count - take;
    res.seq_length  = take;
    res.last_of_run = (remain == 3'd0);
    res_valid       = run_valid;
    advance         = run_valid && out_ready;
    can_load        = !run_valid || (advance && res.last_of_run);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_valid <= 1'b0;
    end else if (run_load) begin
      run_valid <= 1'b1;
    end else if (advance) begin
      run_valid <= !res.last_of_run;
    end
  end

  // Drop the consumed bytes from the head.
  always_ff @(posedge clk) begin
    if (run_load) begin
      run <= run_in;
    end else if (advance) begin
      run.bytes <= run.bytes >> {take, 3'b000};
      run.count <= remain;
    end
  end

  `U8D_ASSERT_IMPL(a_load_has_room, run_load, can_load, "run loaded while scanner busy")
  `U8D_ASSERT_IMPL(a_run_count, run_valid,
                   run.count != 3'd0 && run.count <= 3'(u8d_pkg::RUN_DEPTH),
                   "run length out of range")

endmodule

/* rtl/utf8_stream_decoder.sv */
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// Legacy UTF-8 decoder for one- to six-byte sequences over stream channels.
// ----------------------------------------------------------------------------
// Input channel s_*: one text byte per transfer in s_tdata, s_tlast on the
// final byte of a string. Output channel m_*: one character per transfer,
// m_tdata = {seq_length, code_point}, m_tuser = Latin-1 pass-through flag,
// m_tlast = final character caused by that input byte.
// A byte that completes a sequence, stands alone or ends the string yields
// its first character via the scanner run register and the output register;
// bytes inside an open sequence yield nothing. One byte is taken per cycle while
// s_tready is high. A string end inside an open sequence rescans the held bytes,
// giving up to six characters at one per cycle while the receiver is ready, and the
// input waits while the run scanner is still busy with all but its final character.
// Reset clears the open sequence and any run or character not yet delivered.
// When the receiver stalls, the output register holds its character and the
// scanner holds its run; once the scanner holds a run, s_tready drops.
// ----------------------------------------------------------------------------
`include "utf8_stream_decoder_macros.svh"

module utf8_stream_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tlast,   // end_of_string
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [31:0] code_point, [34:32] seq_length, [39:35] zero
  output logic        m_tuser,   // latin1_fallback
  output logic        m_tlast    // last_of_run
);

  logic             accept;
  logic             run_load;
  u8d_pkg::run_t    run_in;
  logic             can_load;
  logic             res_valid;
  u8d_pkg::result_t res;
  u8d_pkg::result_t out_q;
  logic             out_ready;

  assign s_tready  = can_load;
  assign accept    = s_tvalid && s_tready;
  assign out_ready = !m_tvalid || m_tready;

  u8d_assembler u_assembler (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .data_byte     (s_tdata),
    .end_of_string (s_tlast),
    .run_load      (run_load),
    .run_in        (run_in)
  );

  u8d_scanner u_scanner (
    .clk       (clk),
    .rst       (rst),
    .run_load  (run_load),
    .run_in    (run_in),
    .out_ready (out_ready),
    .can_load  (can_load),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_ready) begin
      m_tvalid <= res_valid;
    end
  end

  // Advance the output register when it is empty or its transfer completes.
  always_ff @(posedge clk) begin
    if (out_ready && res_valid) out_q <= res;
  end

  assign m_tdata = {5'b00000, out_q.seq_length, out_q.code_point};
  assign m_tuser = out_q.latin1_fallback;
  assign m_tlast = out_q.last_of_run;

  `U8D_ASSERT_IMPL(a_latin1_single, m_tvalid && m_tuser, m_tdata[34:32] == 3'd1,
                   "Latin-1 character with length other than one")
  `U8D_ASSERT_IMPL(a_len_nonzero, m_tvalid,
                   m_tdata[34:32] != 3'd0 && m_tdata[34:32] <= 3'(u8d_pkg::RUN_DEPTH),
                   "character length out of range")

endmodule

/* dv/utf8_stream_decoder_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_stream_decoder_test
// Streams legacy UTF-8 text of one- to six-byte sequences into the decoder:
// a directed pass over boundary bytes, every sequence length and end-of-string
// rescans, then random well-formed, truncated and noise strings. A scoreboard
// predicts each character and compares every output transfer in order while
// both channels stall at random.
// ----------------------------------------------------------------------------

class utf8_scoreboard;
  u8d_pkg::result_t pending_chars[$];
  bit [7:0]         held[5];
  int               held_cnt;
  int               want_len;
  int               errors;

  function void clear_seq();
    held_cnt = 0;
    want_len = 0;
  endfunction

  function int lead_length(bit [7:0] b);
    casez (b)
      8'b0???_????, 8'b10??_????: return 1;
      8'b110?_????:               return 2;
      8'b1110_????:               return 3;
      8'b1111_0???:               return 4;
      8'b1111_10??:               return 5;
      default:                    return 6;
    endcase
  endfunction

  // Lead payload, then six bits from each continuation byte.
  function bit [31:0] assemble(bit [7:0] run[6], int first, int n);
    bit [31:0] v;
    case (n)
      2:       v = 32'(run[first] & 8'h1F);
      3:       v = 32'(run[first] & 8'h0F);
      4:       v = 32'(run[first] & 8'h07);
      default: v = 32'(run[first] & 8'h03);
    endcase
    for (int i = 1; i < n; i++) v = (v << 6) | 32'(run[first+i][5:0]);
    return v;
  endfunction

  function void push_char(bit [31:0] cp, int len, bit latin, bit last);
    u8d_pkg::result_t c;
    c.code_point      = cp;
    c.seq_length      = len[2:0];
    c.latin1_fallback = latin;
    c.last_of_run     = last;
    pending_chars.push_back(c);
  endfunction

  function void absorb_byte(bit [7:0] b, bit eos);
    bit [7:0] run[6];
    int       m;
    int       p;
    int       n;
    if (held_cnt > 5 || (held_cnt > 0 && held_cnt >= want_len)) clear_seq();
    for (int i = 0; i < held_cnt; i++) run[i] = held[i];
    run[held_cnt] = b;
    m = held_cnt + 1;
    if (!eos) begin
      if (held_cnt == 0) begin
        n = lead_length(b);
        if (n == 1) begin
          push_char(32'(b), 1, b[7], 1'b1);
        end else begin
          held[0]  = b;
          held_cnt = 1;
          want_len = n;
        end
      end else if (m == want_len) begin
        push_char(assemble(run, 0, m), m, 1'b0, 1'b1);
        clear_seq();
      end else begin
        held[held_cnt] = b;
        held_cnt       = m;
      end
      return;
    end
    // String end: rescan everything held, a lead that cannot fit goes out alone
    p = 0;
    while (p < m) begin
      n = lead_length(run[p]);
      if (n == 1 || p + n > m) begin
        push_char(32'(run[p]), 1, run[p][7], p + 1 == m);
        p += 1;
      end else begin
        push_char(assemble(run, p, n), n, 1'b0, p + n == m);
        p += n;
      end
    end
    clear_seq();
  endfunction

  function void check_char(u8d_pkg::result_t got);
    u8d_pkg::result_t exp;
    if (pending_chars.size() == 0) begin
      $error("unexpected character: code_point %h", got.code_point);
      errors++;
      return;
    end
    exp = pending_chars.pop_front();
    if (got.code_point !== exp.code_point) begin
      $error("code_point: expected %h, got %h", exp.code_point, got.code_point);
      errors++;
    end
    if (got.seq_length !== exp.seq_length) begin
      $error("seq_length: expected %0d, got %0d", exp.seq_length, got.seq_length);
      errors++;
    end
    if (got.latin1_fallback !== exp.latin1_fallback) begin
      $error("latin1_fallback: expected %b, got %b", exp.latin1_fallback,
             got.latin1_fallback);
      errors++;
    end
    if (got.last_of_run !== exp.last_of_run) begin
      $error("last_of_run: expected %b, got %b", exp.last_of_run, got.last_of_run);
      errors++;
    end
  endfunction
endclass

module utf8_stream_decoder_test;
  localparam int TEXT_BYTES   = 280;
  localparam int LIMIT_CYCLES = 200000;
  localparam int DRAIN_CYCLES = 16;
  localparam int DIRECTED_LEN = 28;

  // {end_of_string, data_byte}
  localparam bit [8:0] DIRECTED[DIRECTED_LEN] = '{
    9'h000, 9'h080,                                   // ASCII and Latin-1 floor
    9'h0DF, 9'h0BF,                                   // two-byte, top values
    9'h0EF, 9'h080, 9'h080,                           // three-byte
    9'h0F7, 9'h0BF, 9'h0BF, 9'h0BF,                   // four-byte
    9'h0FB, 9'h080, 9'h0BF, 9'h000, 9'h0FF,           // five-byte, raw continuations
    9'h0FF, 9'h0FF, 9'h0FF, 9'h0FF, 9'h0FF, 9'h1FF,   // six-byte, all ones, end fits
    9'h0FC, 9'h0F8, 9'h0C3, 9'h0A9, 9'h17F,           // end inside open sequence
    9'h1F0                                            // end on a lone lead
  };

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;

  utf8_scoreboard sb = new();
  bit             calm;
  int             sent;

  utf8_stream_decoder DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("utf8_stream_decoder_test NOT OK");
    $finish;
  end

  function automatic int draw_gap();
    return calm ? 0 : $urandom_range(0, 4);
  endfunction

  function automatic bit [7:0] lead_for(int n);
    case (n)
      1:       return 8'($urandom_range(8'h00, 8'hBF));
      2:       return 8'($urandom_range(8'hC0, 8'hDF));
      3:       return 8'($urandom_range(8'hE0, 8'hEF));
      4:       return 8'($urandom_range(8'hF0, 8'hF7));
      5:       return 8'($urandom_range(8'hF8, 8'hFB));
      default: return 8'($urandom_range(8'hFC, 8'hFF));
    endcase
  endfunction

  task automatic send_byte(bit [7:0] b, bit eos);
    int gap;
    gap = draw_gap();
    @(negedge clk);
    if (gap != 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = b;
    s_tlast  = eos;
    do @(posedge clk); while (!s_tready);
    sb.absorb_byte(b, eos);
    sent++;
    calm = ((sent / 40) % 3 == 1);
  endtask

  // Character sink: stall a random number of cycles before each transfer
  initial begin
    u8d_pkg::result_t got;
    int               stall;
    @(negedge rst);
    forever begin
      stall = draw_gap();
      @(negedge clk);
      if (stall != 0) begin
        m_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready = 1'b1;
      do @(posedge clk); while (!m_tvalid);
      got.code_point      = m_tdata[31:0];
      got.seq_length      = m_tdata[34:32];
      got.latin1_fallback = m_tuser;
      got.last_of_run     = m_tlast;
      sb.check_char(got);
    end
  end

  initial begin
    int       kind;
    int       n;
    int       cut;
    bit       eos_last;
    bit [7:0] b;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int i = 0; i < DIRECTED_LEN; i++) send_byte(DIRECTED[i][7:0], DIRECTED[i][8]);

    // Mostly well-formed sequences, some cut short by a string end, some noise
    while (sent < TEXT_BYTES) begin
      kind = $urandom_range(0, 9);
      if (kind == 9) begin
        send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end else begin
        n        = (kind <= 6) ? $urandom_range(1, 6) : $urandom_range(2, 6);
        cut      = (kind <= 6) ? n : $urandom_range(1, n - 1);
        eos_last = (kind <= 6) ? ($urandom_range(0, 3) == 0) : 1'b1;
        for (int i = 0; i < cut; i++) begin
          if (i == 0) b = lead_for(n);
          else if (kind <= 6 && $urandom_range(0, 3) != 0) b = 8'($urandom_range(8'h80, 8'hBF));
          else b = 8'($urandom_range(0, 255));
          send_byte(b, eos_last && i == cut - 1);
        end
      end
    end
    @(negedge clk);
    s_tvalid = 1'b0;

    while (sb.pending_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending_chars.size() != 0) begin
      $error("%0d characters never arrived", sb.pending_chars.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("utf8_stream_decoder_test OK");
    end else begin
      $display("utf8_stream_decoder_test NOT OK");
    end
    $finish;
  end
endmodule

/* filelist.f */
+incdir+rtl
rtl/u8d_pkg.sv
rtl/u8d_assembler.sv
rtl/u8d_scanner.sv
rtl/utf8_stream_decoder.sv
dv/utf8_stream_decoder_test.sv
